// ===== hdl/itss_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itss_pkg
// Shared widths, register codes and beat types of the tile split unit.
// ----------------------------------------------------------------------------
package itss_pkg;

	localparam int COORD_W   = 14;
	localparam int NUM_W     = 12;
	localparam int TOTAL_W   = 13;
	localparam int TILE_MAX  = 4096;
	localparam int CFG_IDX_W = 2;
	// halving steps run 0..NUM_W, so the step count needs this many bits
	localparam int SH_W      = $clog2(NUM_W + 1);
	localparam int MUL_W     = COORD_W + TOTAL_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_START = 2'd0,
		REG_X_END   = 2'd1,
		REG_Y_START = 2'd2,
		REG_Y_END   = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [NUM_W-1:0]   tile_number;
		logic [TOTAL_W-1:0] tile_total;
	} req_t;

	typedef struct packed {
		logic [COORD_W-1:0] tile_x_start;
		logic [COORD_W-1:0] tile_x_end;
		logic [COORD_W-1:0] tile_y_start;
		logic [COORD_W-1:0] tile_y_end;
		logic               tile_empty;
	} rsp_t;

endpackage
`default_nettype wire

// ===== hdl/itss_div_pipe.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itss_div_pipe
// Pipelined restoring divider: one quotient bit per stage, shared divisor,
// LANES dividends in parallel, side data carried along with the valid bit.
// ----------------------------------------------------------------------------
module itss_div_pipe #(
	parameter int NUM_W  = 12,
	parameter int DEN_W  = 13,
	parameter int SIDE_W = 1,
	parameter int LANES  = 1
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	input  wire logic [LANES-1:0][NUM_W-1:0]      in_num,
	input  wire logic [DEN_W-1:0]                 in_den,
	input  wire logic [SIDE_W-1:0]                in_side,
	output logic                                  out_valid,
	output logic      [LANES-1:0][NUM_W-1:0]      out_quo,
	output logic      [LANES-1:0][DEN_W-1:0]      out_rem,
	output logic      [SIDE_W-1:0]                out_side
);

	logic                          vld_s  [NUM_W+1];
	logic [LANES-1:0][NUM_W-1:0]   num_s  [NUM_W+1];
	logic [LANES-1:0][NUM_W-1:0]   quo_s  [NUM_W+1];
	logic [LANES-1:0][DEN_W-1:0]   rem_s  [NUM_W+1];
	logic [DEN_W-1:0]              den_s  [NUM_W+1];
	logic [SIDE_W-1:0]             side_s [NUM_W+1];

	assign vld_s[0]  = in_valid;
	assign num_s[0]  = in_num;
	assign quo_s[0]  = '0;
	assign rem_s[0]  = '0;
	assign den_s[0]  = in_den;
	assign side_s[0] = in_side;

	for (genvar st = 0; st < NUM_W; st++) begin : g_stage
		logic [LANES-1:0][DEN_W-1:0] rem_nx;
		logic [LANES-1:0][NUM_W-1:0] quo_nx;
		logic [LANES-1:0][NUM_W-1:0] num_nx;

		always_comb begin
			logic [DEN_W:0] trial;
			logic           ge;
			for (int ln = 0; ln < LANES; ln++) begin
				trial = {rem_s[st][ln], num_s[st][ln][NUM_W-1]};
				ge    = trial >= {1'b0, den_s[st]};
				rem_nx[ln] = ge ? DEN_W'(trial - {1'b0, den_s[st]}) : trial[DEN_W-1:0];
				quo_nx[ln] = {quo_s[st][ln][NUM_W-2:0], ge};
				num_nx[ln] = {num_s[st][ln][NUM_W-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[st+1] <= 1'b0;
			end else begin
				vld_s[st+1] <= vld_s[st];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[st+1]  <= rem_nx;
			quo_s[st+1]  <= quo_nx;
			num_s[st+1]  <= num_nx;
			den_s[st+1]  <= den_s[st];
			side_s[st+1] <= side_s[st];
		end
	end

	assign out_valid = vld_s[NUM_W];
	assign out_quo   = quo_s[NUM_W];
	assign out_rem   = rem_s[NUM_W];
	assign out_side  = side_s[NUM_W];

endmodule
`default_nettype wire

// ===== hdl/image_tile_subwindow_split_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// image_tile_subwindow_split_unit
// Splits the configured pixel window into a near-square grid and returns the
// pixel bounds of one requested tile.
// ----------------------------------------------------------------------------
// Usage:
//   Program the window through cfg_wr_en / cfg_addr / cfg_wdata while no
//   request is in flight. Issue a request beat by raising start with req
//   (tile number and tile count); it is taken on any edge where busy is low.
//   For each request beat, done pulses for one cycle with rsp valid.
//   The receiver cannot stall, so there is no back-pressure anywhere.
// Throughput: one request per cycle when not busy. The pipeline is: input
//   stage with the dy*count multiply, grid-shape stage, a 12-stage divider
//   for column/row, a multiply stage, a 27-stage two-lane divider for the x
//   bounds, and the result register. The long x divider sets the latency.
// Out-of-range requests (count zero, count above the maximum, or number not
//   below count) flow through and come out as all-zero bounds, empty set.
// Reset: clears the window registers and all valid bits; busy is high in
//   reset and until the busy register is clocked after it.
// ----------------------------------------------------------------------------
module image_tile_subwindow_split_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire itss_pkg::req_t                      req,
	output logic                                     done,
	output itss_pkg::rsp_t                           rsp,
	input  wire logic                                cfg_wr_en,
	input  wire logic [itss_pkg::CFG_IDX_W-1:0]      cfg_addr,
	input  wire logic [itss_pkg::COORD_W-1:0]        cfg_wdata
);

	localparam int CW   = itss_pkg::COORD_W;
	localparam int TW   = itss_pkg::TOTAL_W;
	localparam int NW   = itss_pkg::NUM_W;
	localparam int SW   = itss_pkg::SH_W;
	localparam int MW   = itss_pkg::MUL_W;
	// widest shifted 2*dx term of the shape test
	localparam int CMPW = CW + 1 + 2 * NW;
	localparam int SIDE1_W = 1 + SW + TW;
	localparam int SIDE2_W = 1 + 2 * CW;
	localparam int LATENCY = 2 + NW + 1 + MW + 1;

	// Window registers
	logic [CW-1:0] x_start_q, x_end_q, y_start_q, y_end_q;
	logic          busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_start_q <= '0;
			x_end_q   <= '0;
			y_start_q <= '0;
			y_end_q   <= '0;
		end else if (cfg_wr_en) begin
			unique case (itss_pkg::cfg_reg_t'(cfg_addr))
				itss_pkg::REG_X_START: x_start_q <= cfg_wdata;
				itss_pkg::REG_X_END:   x_end_q   <= cfg_wdata;
				itss_pkg::REG_Y_START: y_start_q <= cfg_wdata;
				itss_pkg::REG_Y_END:   y_end_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end
	assign busy = busy_q;

	// Extents; an inverted window counts as zero
	logic [CW-1:0] dx, dy;
	assign dx = (x_end_q >= x_start_q) ? CW'(x_end_q - x_start_q) : '0;
	assign dy = (y_end_q >= y_start_q) ? CW'(y_end_q - y_start_q) : '0;

	// Stage 1: guard, dy*count
	logic          acc;
	logic          bad_in;
	logic          vld_s1, bad_s1;
	logic [NW-1:0] num_s1;
	logic [TW-1:0] tot_s1;
	logic [MW-1:0] prod_s1;
	logic [CW:0]   dd_s1;

	assign acc    = start && !busy_q;
	assign bad_in = (req.tile_total == '0) ||
	                (req.tile_total > TW'(itss_pkg::TILE_MAX)) ||
	                ({1'b0, req.tile_number} >= req.tile_total);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		bad_s1  <= bad_in;
		num_s1  <= req.tile_number;
		tot_s1  <= req.tile_total;
		prod_s1 <= MW'(dy * req.tile_total);
		dd_s1   <= {dx, 1'b0};
	end

	// Stage 2: grid shape. Step i continues while count bit i is clear and
	// (2*dx) << 2i stays below dy*count, the scaled form of 2*dx*ny < dy*nx.
	logic [SW-1:0] sh;
	always_comb begin
		logic run;
		logic [CMPW-1:0] lhs;
		sh  = '0;
		run = 1'b1;
		for (int i = 0; i < NW; i++) begin
			lhs = CMPW'(dd_s1) << (2 * i);
			if (run && !tot_s1[i] && (lhs < CMPW'(prod_s1))) begin
				sh = SW'(i + 1);
			end else begin
				run = 1'b0;
			end
		end
	end

	logic          vld_s2, bad_s2;
	logic [NW-1:0] num_s2;
	logic [TW-1:0] nx_s2;
	logic [SW-1:0] sh_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		bad_s2 <= bad_s1;
		num_s2 <= num_s1;
		nx_s2  <= tot_s1 >> sh;
		sh_s2  <= sh;
	end

	// Column and row: number / nx
	logic               d1_vld;
	logic [0:0][NW-1:0] d1_quo;
	logic [0:0][TW-1:0] d1_rem;
	logic [SIDE1_W-1:0] d1_side;

	itss_div_pipe #(
		.NUM_W (NW),
		.DEN_W (TW),
		.SIDE_W(SIDE1_W),
		.LANES (1)
	) u_div_grid (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s2),
		.in_num   (num_s2),
		.in_den   (nx_s2),
		.in_side  ({bad_s2, sh_s2, nx_s2}),
		.out_valid(d1_vld),
		.out_quo  (d1_quo),
		.out_rem  (d1_rem),
		.out_side (d1_side)
	);

	// Stage 3: k*extent products for both axes
	logic          vld_s3, bad_s3;
	logic [SW-1:0] sh_s3;
	logic [TW-1:0] nx_s3;
	logic [MW-1:0] mx0_s3, mx1_s3, my0_s3, my1_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= d1_vld;
		end
	end

	always_ff @(posedge clk) begin
		bad_s3 <= d1_side[SIDE1_W-1];
		sh_s3  <= d1_side[TW +: SW];
		nx_s3  <= d1_side[TW-1:0];
		mx0_s3 <= MW'(d1_rem[0] * dx);
		mx1_s3 <= MW'((d1_rem[0] + TW'(1)) * dx);
		my0_s3 <= MW'(d1_quo[0] * dy);
		my1_s3 <= MW'(({1'b0, d1_quo[0]} + TW'(1)) * dy);
	end

	// y bounds divide by a power of two: shift and add
	logic [CW-1:0] y0, y1;
	assign y0 = CW'(MW'(y_start_q) + (my0_s3 >> sh_s3));
	assign y1 = CW'(MW'(y_start_q) + (my1_s3 >> sh_s3));

	// x bounds: k*dx / nx, two lanes
	logic               d2_vld;
	logic [1:0][MW-1:0] d2_quo;
	logic [SIDE2_W-1:0] d2_side;

	itss_div_pipe #(
		.NUM_W (MW),
		.DEN_W (TW),
		.SIDE_W(SIDE2_W),
		.LANES (2)
	) u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s3),
		.in_num   ({mx1_s3, mx0_s3}),
		.in_den   (nx_s3),
		.in_side  ({bad_s3, y0, y1}),
		.out_valid(d2_vld),
		.out_quo  (d2_quo),
		.out_rem  (),
		.out_side (d2_side)
	);

	// Result register
	logic          bad_out;
	logic [CW-1:0] x0, x1, y0_out, y1_out;
	assign bad_out = d2_side[SIDE2_W-1];
	assign y0_out  = d2_side[CW +: CW];
	assign y1_out  = d2_side[CW-1:0];
	assign x0      = CW'(x_start_q + d2_quo[0][CW-1:0]);
	assign x1      = CW'(x_start_q + d2_quo[1][CW-1:0]);

	logic           done_q;
	itss_pkg::rsp_t rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= d2_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (bad_out) begin
			rsp_q <= '{tile_x_start: '0, tile_x_end: '0, tile_y_start: '0,
			           tile_y_end: '0, tile_empty: 1'b1};
		end else begin
			rsp_q <= '{tile_x_start: x0, tile_x_end: x1, tile_y_start: y0_out,
			           tile_y_end: y1_out, tile_empty: (x0 == x1) || (y0_out == y1_out)};
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	// Assertions
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("request beat did not complete after the pipeline latency");

	a_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.tile_empty) |->
		(rsp.tile_x_start != rsp.tile_x_end) && (rsp.tile_y_start != rsp.tile_y_end))
		else $error("tile with a zero span not flagged empty");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s3 && !bad_s3) |-> (nx_s3 != '0))
		else $error("valid in-range beat reached the x divider with a zero divisor");

endmodule
`default_nettype wire

// ===== test/tb_image_tile_subwindow_split_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_image_tile_subwindow_split_unit
// Drives tile requests into the tile split unit across several window
// settings and checks every returned tile against a predictor or a table.
// ----------------------------------------------------------------------------
module tb_image_tile_subwindow_split_unit;

	localparam int CLK_HALF    = 6;
	localparam int LATENCY     = 43;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RAND_ITEMS  = 1950;

	logic                           clk;
	logic                           arst_n;
	logic                           start;
	logic                           busy;
	itss_pkg::req_t                 req;
	logic                           done;
	itss_pkg::rsp_t                 rsp;
	logic                           cfg_wr_en;
	logic [itss_pkg::CFG_IDX_W-1:0] cfg_addr;
	logic [itss_pkg::COORD_W-1:0]   cfg_wdata;

	image_tile_subwindow_split_unit uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	// window copy held by the predictor
	logic [itss_pkg::COORD_W-1:0] win_x0, win_x1, win_y0, win_y1;
	itss_pkg::rsp_t               pending_tiles[$];
	int                           err_count;
	int                           cycle_count;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Abort on a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
		err_count++;
	endtask

	// Compute the tile bounds exactly, with wide integers.
	function automatic itss_pkg::rsp_t tile_bounds(input itss_pkg::req_t r);
		itss_pkg::rsp_t  t;
		longint unsigned dx, dy, nx, ny, col, row;
		t = '0;
		if (r.tile_total == 0 || r.tile_total > itss_pkg::TILE_MAX ||
		    r.tile_number >= r.tile_total) begin
			t.tile_empty = 1'b1;
			return t;
		end
		dx = (win_x1 >= win_x0) ? win_x1 - win_x0 : 0;
		dy = (win_y1 >= win_y0) ? win_y1 - win_y0 : 0;
		nx = r.tile_total;
		ny = 1;
		while (nx[0] == 1'b0 && 2 * dx * ny < dy * nx) begin
			nx = nx >> 1;
			ny = ny << 1;
		end
		col = r.tile_number % nx;
		row = r.tile_number / nx;
		t.tile_x_start = itss_pkg::COORD_W'(win_x0 + (col * dx) / nx);
		t.tile_x_end   = itss_pkg::COORD_W'(win_x0 + ((col + 1) * dx) / nx);
		t.tile_y_start = itss_pkg::COORD_W'(win_y0 + (row * dy) / ny);
		t.tile_y_end   = itss_pkg::COORD_W'(win_y0 + ((row + 1) * dy) / ny);
		t.tile_empty   = (t.tile_x_start == t.tile_x_end) ||
		                 (t.tile_y_start == t.tile_y_end);
		return t;
	endfunction

	// Compare each done beat with the oldest expected tile.
	always @(posedge clk) begin
		itss_pkg::rsp_t want;
		if (arst_n && done) begin
			if (pending_tiles.size() == 0) begin
				report_mismatch("unexpected beat", 1, 0);
			end else begin
				want = pending_tiles.pop_front();
				if (rsp.tile_x_start !== want.tile_x_start)
					report_mismatch("tile_x_start", rsp.tile_x_start, want.tile_x_start);
				if (rsp.tile_x_end !== want.tile_x_end)
					report_mismatch("tile_x_end", rsp.tile_x_end, want.tile_x_end);
				if (rsp.tile_y_start !== want.tile_y_start)
					report_mismatch("tile_y_start", rsp.tile_y_start, want.tile_y_start);
				if (rsp.tile_y_end !== want.tile_y_end)
					report_mismatch("tile_y_end", rsp.tile_y_end, want.tile_y_end);
				if (rsp.tile_empty !== want.tile_empty)
					report_mismatch("tile_empty", rsp.tile_empty, want.tile_empty);
			end
		end
	end

	// Write one window register; the block must be idle. The caller drops
	// the write enable after the last register.
	task automatic write_window(input itss_pkg::cfg_reg_t idx,
	                            input logic [itss_pkg::COORD_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			itss_pkg::REG_X_START: win_x0 = val;
			itss_pkg::REG_X_END:   win_x1 = val;
			itss_pkg::REG_Y_START: win_y0 = val;
			itss_pkg::REG_Y_END:   win_y1 = val;
		endcase
	endtask

	task automatic set_window(input int x0, input int x1, input int y0, input int y1);
		write_window(itss_pkg::REG_X_START, itss_pkg::COORD_W'(x0));
		write_window(itss_pkg::REG_X_END, itss_pkg::COORD_W'(x1));
		write_window(itss_pkg::REG_Y_START, itss_pkg::COORD_W'(y0));
		write_window(itss_pkg::REG_Y_END, itss_pkg::COORD_W'(y1));
		cfg_wr_en <= 1'b0;
	endtask

	// Drain outstanding beats before touching the window.
	task automatic wait_idle();
		while (pending_tiles.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Send one request beat; hold start until taken, then maybe idle.
	task automatic send_tile(input itss_pkg::req_t r, input itss_pkg::rsp_t want,
	                         input bit quiet);
		start <= 1'b1;
		req   <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_tiles.push_back(want);
		if (!quiet && $urandom_range(99) < 8) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic drop_start();
		start <= 1'b0;
		@(posedge clk);
	endtask

	// Draw a request: mostly valid numbers, counts often powers of two.
	function automatic itss_pkg::req_t random_tile();
		itss_pkg::req_t r;
		int             sel;
		sel = $urandom_range(99);
		if (sel < 40)
			r.tile_total = itss_pkg::TOTAL_W'(1 << $urandom_range(0, 12));
		else if (sel < 90)
			r.tile_total = itss_pkg::TOTAL_W'($urandom_range(1, itss_pkg::TILE_MAX));
		else
			r.tile_total = itss_pkg::TOTAL_W'($urandom);
		if ($urandom_range(9) == 0 || r.tile_total == 0)
			r.tile_number = itss_pkg::NUM_W'($urandom);
		else
			r.tile_number = itss_pkg::NUM_W'($urandom_range(0,
				(r.tile_total > itss_pkg::TILE_MAX ? itss_pkg::TILE_MAX : r.tile_total) - 1));
		return r;
	endfunction

	typedef struct {
		int             num;
		int             total;
		bit             typed;
		itss_pkg::rsp_t want;
	} dir_row_t;

	dir_row_t dir_rows[] = '{
		// reset window, zero extents: all empty
		'{0, 1, 1, '{0, 0, 0, 0, 1'b1}},
		// count zero
		'{0, 0, 1, '{0, 0, 0, 0, 1'b1}},
		// count above the maximum
		'{0, 4097, 1, '{0, 0, 0, 0, 1'b1}},
		'{4095, 8191, 1, '{0, 0, 0, 0, 1'b1}},
		// number not below count
		'{5, 5, 1, '{0, 0, 0, 0, 1'b1}},
		'{4095, 4095, 1, '{0, 0, 0, 0, 1'b1}},
		'{0, 4096, 0, '0},
		'{4095, 4096, 0, '0},
		'{3, 4, 0, '0},
		'{1, 2, 0, '0},
		'{6, 7, 0, '0},
		'{2047, 2048, 0, '0},
		'{100, 1000, 0, '0}
	};

	initial begin
		itss_pkg::req_t r;
		arst_n      = 1'b0;
		start       = 1'b0;
		req         = '0;
		cfg_wr_en   = 1'b0;
		cfg_addr    = itss_pkg::REG_X_START;
		cfg_wdata   = '0;
		win_x0      = '0;
		win_x1      = '0;
		win_y0      = '0;
		win_y1      = '0;
		err_count   = 0;
		cycle_count = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed rows: first six rows on the reset window, then full range.
		foreach (dir_rows[i]) begin
			if (i == 6) begin
				drop_start();
				wait_idle();
				set_window(0, 16383, 0, 16383);
			end
			r.tile_number = itss_pkg::NUM_W'(dir_rows[i].num);
			r.tile_total  = itss_pkg::TOTAL_W'(dir_rows[i].total);
			send_tile(r, dir_rows[i].typed ? dir_rows[i].want : tile_bounds(r), 1'b1);
		end
		drop_start();
		wait_idle();
		// reversed window: both extents count as zero
		set_window(16383, 0, 9000, 100);
		r = '{0, 1};
		send_tile(r, tile_bounds(r), 1'b1);
		r = '{7, 16};
		send_tile(r, tile_bounds(r), 1'b1);
		drop_start();

		// Random phases over several windows, extremes included.
		for (int ph = 0; ph < 8; ph++) begin
			wait_idle();
			case (ph)
				0: set_window(0, 16383, 0, 1);
				1: set_window(0, 1, 0, 16383);
				2: set_window(16383, 16383, 0, 16383);
				default: set_window($urandom_range(0, 16383), $urandom_range(0, 16383),
					$urandom_range(0, 4000), $urandom_range(0, 16383));
			endcase
			for (int n = 0; n < RAND_ITEMS / 8; n++) begin
				r = random_tile();
				send_tile(r, tile_bounds(r), ph == 4);
			end
			drop_start();
		end

		wait_idle();
		repeat (LATENCY + 10) @(posedge clk);
		if (err_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== image_tile_subwindow_split_unit.f =====
hdl/itss_pkg.sv
hdl/itss_div_pipe.sv
hdl/image_tile_subwindow_split_unit.sv
test/tb_image_tile_subwindow_split_unit.sv
